[rtl/enms_pkg.sv]
`timescale 1ns / 1ps

package enms_pkg;

    // Sizes of the pixel stream and of the line storage
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAG_BITS   = 11;
    localparam int GRAD_BITS  = 11;

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int ROW_BITS = $clog2(MAX_HEIGHT);
    localparam int W_BITS   = 12;
    localparam int H_BITS   = 13;

    // Cross-multiplication widths
    localparam int PROD_BITS = GRAD_BITS + MAG_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;

    // Result queue
    localparam int FIFO_DEPTH    = 8;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int CREDIT_BITS   = $clog2(FIFO_DEPTH + 1);

    // Configuration port
    localparam int CFG_DATA_BITS = 13;

    typedef logic [MAG_BITS-1:0]         t_mag;
    typedef logic signed [GRAD_BITS-1:0] t_grad;
    typedef logic [GRAD_BITS-1:0]        t_axis;
    typedef logic [COL_BITS-1:0]         t_col;
    typedef logic [ROW_BITS-1:0]         t_row;
    typedef logic [W_BITS-1:0]           t_width;
    typedef logic [H_BITS-1:0]           t_height;
    typedef logic [PROD_BITS-1:0]        t_prod;
    typedef logic [SUM_BITS-1:0]         t_sum;

    localparam t_width  WIDTH_MIN    = W_BITS'(3);
    localparam t_width  WIDTH_MAX    = W_BITS'(MAX_WIDTH);
    localparam t_width  WIDTH_RESET  = W_BITS'(640);
    localparam t_height HEIGHT_MIN   = H_BITS'(3);
    localparam t_height HEIGHT_MAX   = H_BITS'(MAX_HEIGHT);
    localparam t_height HEIGHT_RESET = H_BITS'(480);

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_index;

    // Centre pixel with its window, handed from the line buffer to the decision pipe
    typedef struct packed {
        logic                 live;
        logic                 res_valid;
        logic                 border;
        t_mag [2:0][2:0]      win;
        t_grad                gx;
        t_grad                gy;
    } t_cand;

    // One queued output request
    typedef struct packed {
        t_mag magnitude;
        logic res_valid;
    } t_result;

endpackage

[rtl/enms_ram.sv]
`timescale 1ns / 1ps

module enms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Simple dual port; a read colliding with a write returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/enms_window.sv]
`timescale 1ns / 1ps

module enms_window import enms_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  t_mag    i_magnitude,
    input  t_grad   i_grad_x,
    input  t_grad   i_grad_y,
    input  logic    i_frame_start,
    input  t_width  i_width,
    input  t_height i_height,
    output t_cand   o_cand
);

    // Raster position
    t_col r_col;
    t_row r_row;
    t_col n_col;
    t_row n_row;
    t_col col_c;
    t_row row_c;

    // Stage 1: line read in flight
    logic  r_s1_v;
    logic  r_s1_hz;
    t_col  r_s1_col;
    t_row  r_s1_row;
    t_mag  r_s1_mag;
    t_grad r_s1_gx;
    t_grad r_s1_gy;

    // Last write, forwarded when the next request reads the same column
    logic [2*MAG_BITS-1:0]  r_fwd_mag;
    logic [2*GRAD_BITS-1:0] r_fwd_grad;

    logic [2*MAG_BITS-1:0]  rd_mag;
    logic [2*GRAD_BITS-1:0] rd_grad;
    logic [2*MAG_BITS-1:0]  line_mag;
    logic [2*GRAD_BITS-1:0] line_grad;
    logic [2*MAG_BITS-1:0]  wr_mag;
    logic [2*GRAD_BITS-1:0] wr_grad;

    t_mag [2:0][2:0]        r_win;
    t_mag [2:0][2:0]        n_win;
    logic [2*GRAD_BITS-1:0] r_grad_delay;
    t_cand                  r_cand;

    logic res_valid;
    logic border;
    t_row rc;
    t_col cc;

    // Position of the incoming pixel and of the one after it
    always_comb begin
        logic [COL_BITS-1:0] col0;
        logic [ROW_BITS:0]   row0;
        logic [COL_BITS:0]   col_inc;
        logic [ROW_BITS:0]   row_inc;
        col0 = i_frame_start ? '0 : r_col;
        row0 = i_frame_start ? '0 : {1'b0, r_row};
        if (W_BITS'(col0) >= i_width) begin
            col0 = '0;
            row0 = row0 + 1'b1;
        end
        if (H_BITS'(row0) >= i_height) begin
            row0 = '0;
        end
        col_c   = col0;
        row_c   = row0[ROW_BITS-1:0];
        col_inc = {1'b0, col_c} + 1'b1;
        row_inc = {1'b0, row_c} + 1'b1;
        n_col   = col_inc[COL_BITS-1:0];
        n_row   = row_c;
        if (W_BITS'(col_inc) >= i_width) begin
            n_col = '0;
            n_row = (H_BITS'(row_inc) >= i_height) ? '0 : row_inc[ROW_BITS-1:0];
        end
    end

    // Line memories: two magnitude rows per word, one gradient pair per word
    enms_ram #(.WIDTH(2*MAG_BITS), .DEPTH(MAX_WIDTH)) u_mag_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_v),
        .i_waddr (r_s1_col),
        .i_wdata (wr_mag),
        .i_re    (i_accept),
        .i_raddr (col_c),
        .o_rdata (rd_mag)
    );

    enms_ram #(.WIDTH(2*GRAD_BITS), .DEPTH(MAX_WIDTH)) u_grad_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_v),
        .i_waddr (r_s1_col),
        .i_wdata (wr_grad),
        .i_re    (i_accept),
        .i_raddr (col_c),
        .o_rdata (rd_grad)
    );

    // Read data with forwarding, write back and window shift
    always_comb begin
        line_mag  = r_s1_hz ? r_fwd_mag  : rd_mag;
        line_grad = r_s1_hz ? r_fwd_grad : rd_grad;
        wr_mag    = {line_mag[MAG_BITS-1:0], r_s1_mag};
        wr_grad   = {r_s1_gy, r_s1_gx};
        for (int k = 0; k < 3; k++) begin
            n_win[k][0] = r_win[k][1];
            n_win[k][1] = r_win[k][2];
        end
        n_win[0][2] = line_mag[2*MAG_BITS-1:MAG_BITS];
        n_win[1][2] = line_mag[MAG_BITS-1:0];
        n_win[2][2] = r_s1_mag;
    end

    // Centre position lags one pixel behind the previous row
    always_comb begin
        res_valid = (r_s1_row >= ROW_BITS'(2))
                 || ((r_s1_row == ROW_BITS'(1)) && (r_s1_col != '0));
        if (r_s1_col != '0) begin
            rc = r_s1_row - 1'b1;
            cc = r_s1_col - 1'b1;
        end else begin
            rc = r_s1_row - ROW_BITS'(2);
            cc = COL_BITS'(i_width - 1'b1);
        end
        border = (rc == '0) || (H_BITS'(rc) >= i_height - 1'b1)
              || (cc == '0) || (W_BITS'(cc) >= i_width - 1'b1);
    end

    // Control, window state and candidate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_s1_v       <= 1'b0;
            r_s1_hz      <= 1'b0;
            r_win        <= '0;
            r_grad_delay <= '0;
            r_cand.live  <= 1'b0;
        end else begin
            r_s1_v      <= i_accept;
            r_cand.live <= r_s1_v;
            if (i_accept) begin
                r_col   <= n_col;
                r_row   <= n_row;
                r_s1_hz <= r_s1_v && (col_c == r_s1_col);
            end
            if (r_s1_v) begin
                r_win            <= n_win;
                r_grad_delay     <= line_grad;
                r_cand.res_valid <= res_valid;
                r_cand.border    <= border;
                r_cand.win       <= n_win;
                r_cand.gx        <= t_grad'(r_grad_delay[GRAD_BITS-1:0]);
                r_cand.gy        <= t_grad'(r_grad_delay[2*GRAD_BITS-1:GRAD_BITS]);
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_col <= col_c;
            r_s1_row <= row_c;
            r_s1_mag <= i_magnitude;
            r_s1_gx  <= i_grad_x;
            r_s1_gy  <= i_grad_y;
        end
        if (r_s1_v) begin
            r_fwd_mag  <= wr_mag;
            r_fwd_grad <= wr_grad;
        end
    end

    assign o_cand = r_cand;

endmodule

[rtl/enms_decide.sv]
`timescale 1ns / 1ps

module enms_decide import enms_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cand   i_cand,
    output logic    o_push,
    output t_result o_res
);

    // Stage 2: axis choice and neighbor selection
    logic  r2_v;
    logic  r2_res_valid;
    logic  r2_keep;
    t_axis r2_major;
    t_axis r2_minor;
    t_axis r2_diff;
    t_mag  r2_m;
    t_mag  r2_v1, r2_v2, r2_v3, r2_v4;

    // Stage 3: products
    logic  r3_v;
    logic  r3_res_valid;
    logic  r3_keep;
    t_mag  r3_m;
    t_prod r3_lhs;
    t_prod r3_p1, r3_p2, r3_p3, r3_p4;

    t_axis major, minor;
    t_mag  v1, v2, v3, v4;
    t_sum  rhs_a, rhs_b;

    always_comb begin
        t_grad gx;
        t_grad gy;
        t_axis ax;
        t_axis ay;
        logic  same;
        gx   = i_cand.gx;
        gy   = i_cand.gy;
        ax   = t_axis'(gx < 0 ? -gx : gx);
        ay   = t_axis'(gy < 0 ? -gy : gy);
        same = ((gx > 0) && (gy > 0)) || ((gx < 0) && (gy < 0));
        if (ay > ax) begin
            major = ay;
            minor = ax;
            v2    = i_cand.win[0][1];
            v4    = i_cand.win[2][1];
            v1    = same ? i_cand.win[0][0] : i_cand.win[0][2];
            v3    = same ? i_cand.win[2][2] : i_cand.win[2][0];
        end else begin
            major = ax;
            minor = ay;
            // no gradient at all: unit weight on the diagonal pair
            if (ax == '0) begin
                major = t_axis'(1);
                minor = t_axis'(1);
            end
            v2 = i_cand.win[1][2];
            v4 = i_cand.win[1][0];
            v1 = same ? i_cand.win[2][2] : i_cand.win[0][2];
            v3 = same ? i_cand.win[0][0] : i_cand.win[2][0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r2_v <= i_cand.live;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_res_valid <= i_cand.res_valid;
        r2_keep      <= i_cand.res_valid && !i_cand.border && (i_cand.win[1][1] != '0);
        r2_major     <= major;
        r2_minor     <= minor;
        r2_diff      <= major - minor;
        r2_m         <= i_cand.win[1][1];
        r2_v1        <= v1;
        r2_v2        <= v2;
        r2_v3        <= v3;
        r2_v4        <= v4;

        r3_res_valid <= r2_res_valid;
        r3_keep      <= r2_keep;
        r3_m         <= r2_m;
        r3_lhs       <= PROD_BITS'(r2_major) * PROD_BITS'(r2_m);
        r3_p1        <= PROD_BITS'(r2_minor) * PROD_BITS'(r2_v1);
        r3_p2        <= PROD_BITS'(r2_diff)  * PROD_BITS'(r2_v2);
        r3_p3        <= PROD_BITS'(r2_minor) * PROD_BITS'(r2_v3);
        r3_p4        <= PROD_BITS'(r2_diff)  * PROD_BITS'(r2_v4);
    end

    // Centre must reach both interpolated neighbors
    always_comb begin
        rhs_a = SUM_BITS'(r3_p1) + SUM_BITS'(r3_p2);
        rhs_b = SUM_BITS'(r3_p3) + SUM_BITS'(r3_p4);
        o_push          = r3_v;
        o_res.res_valid = r3_res_valid;
        o_res.magnitude = (r3_keep && (SUM_BITS'(r3_lhs) >= rhs_a)
                          && (SUM_BITS'(r3_lhs) >= rhs_b)) ? r3_m : '0;
    end

endmodule

[rtl/enms_fifo.sv]
`timescale 1ns / 1ps

module enms_fifo import enms_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    input  logic    i_pop,
    output logic    o_valid,
    output t_result o_data
);

    t_result                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr_ptr;
    logic [FIFO_PTR_BITS-1:0] r_rd_ptr;
    logic [CREDIT_BITS-1:0]   r_count;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CREDIT_BITS'(i_push) - CREDIT_BITS'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

[rtl/edge_nonmax_suppress_interpolated.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// pixel     in         i_valid / o_stall         i_magnitude, i_grad_x, i_grad_y, i_frame_start
// result    out        o_valid / i_stall         o_suppressed_magnitude, o_result_valid
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One pixel per clock unless stalled; a pixel reaches the result queue through the stage-1,
// candidate, stage-2 and stage-3 registers. The column line memories are read and written
// once per pixel; back-to-back hits on the same column (frame restart) are forwarded. An
// 8-entry result queue with credit count parts the two sides, so input stalls only when 8
// requests are outstanding. Reset (synchronous, active low) clears position, window and
// queue; line memories are not cleared.

module edge_nonmax_suppress_interpolated import enms_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  t_mag                     i_magnitude,
    input  t_grad                    i_grad_x,
    input  t_grad                    i_grad_y,
    input  logic                     i_frame_start,
    output logic                     o_valid,
    input  logic                     i_stall,
    output t_mag                     o_suppressed_magnitude,
    output logic                     o_result_valid,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic                     i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_width                 r_width;
    t_height                r_height;
    logic [CREDIT_BITS-1:0] r_credit;

    logic    accept;
    logic    pop;
    logic    push;
    t_cand   cand;
    t_result res;
    t_result head;
    t_width  cfg_width;
    t_height cfg_height;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_credit == CREDIT_BITS'(FIFO_DEPTH));
    assign accept      = i_valid && !o_stall;
    assign pop         = o_valid && !i_stall;

    // Clamp register writes into the supported frame sizes
    always_comb begin
        cfg_width  = i_cfg_data[W_BITS-1:0];
        cfg_height = i_cfg_data[H_BITS-1:0];
        if (cfg_width < WIDTH_MIN) begin
            cfg_width = WIDTH_MIN;
        end else if (cfg_width > WIDTH_MAX) begin
            cfg_width = WIDTH_MAX;
        end
        if (cfg_height < HEIGHT_MIN) begin
            cfg_height = HEIGHT_MIN;
        end else if (cfg_height > HEIGHT_MAX) begin
            cfg_height = HEIGHT_MAX;
        end
    end

    // Config registers and outstanding-request credit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_credit <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_reg_index'(i_cfg_index))
                    REG_IMAGE_WIDTH:  r_width  <= cfg_width;
                    REG_IMAGE_HEIGHT: r_height <= cfg_height;
                    default: ;
                endcase
            end
            r_credit <= r_credit + CREDIT_BITS'(accept) - CREDIT_BITS'(pop);
        end
    end

    enms_window u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_magnitude   (i_magnitude),
        .i_grad_x      (i_grad_x),
        .i_grad_y      (i_grad_y),
        .i_frame_start (i_frame_start),
        .i_width       (r_width),
        .i_height      (r_height),
        .o_cand        (cand)
    );

    enms_decide u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cand  (cand),
        .o_push  (push),
        .o_res   (res)
    );

    enms_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (res),
        .i_pop   (pop),
        .o_valid (o_valid),
        .o_data  (head)
    );

    assign o_suppressed_magnitude = head.magnitude;
    assign o_result_valid         = head.res_valid;

    // Credits bound the queue fill
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CREDIT_BITS'(FIFO_DEPTH))
        else $error("credit count above queue depth");

    // A queued result always has an outstanding credit
    a_out_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_credit != '0))
        else $error("result shown without outstanding request");

    // Every accepted pixel reaches the result queue through the pipe registers
    a_pipe_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##4 push)
        else $error("accepted pixel did not reach the result queue");

    // Nonzero output only for an in-frame centre
    a_zero_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !res.res_valid) |-> (res.magnitude == '0))
        else $error("nonzero magnitude for out-of-frame centre");

endmodule

[tb/edge_nonmax_suppress_interpolated_test.sv]
`timescale 1ns / 1ps

module edge_nonmax_suppress_interpolated_test;
    import enms_pkg::*;

    localparam t_grad GRAD_MOST_NEG = {1'b1, {(GRAD_BITS-1){1'b0}}};

    // Block inputs, all known from time zero
    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    t_mag                     i_magnitude = '0;
    t_grad                    i_grad_x = '0;
    t_grad                    i_grad_y = '0;
    logic                     i_frame_start = 1'b0;
    logic                     i_stall = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic                     i_cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    logic o_stall;
    logic o_valid;
    t_mag o_suppressed_magnitude;
    logic o_result_valid;
    logic o_cfg_ready;

    edge_nonmax_suppress_interpolated dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_stall                (o_stall),
        .i_magnitude            (i_magnitude),
        .i_grad_x               (i_grad_x),
        .i_grad_y               (i_grad_y),
        .i_frame_start          (i_frame_start),
        .o_valid                (o_valid),
        .i_stall                (i_stall),
        .o_suppressed_magnitude (o_suppressed_magnitude),
        .o_result_valid         (o_result_valid),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow of the block: line stores, window, position and sizes
    t_mag                     line_upper [MAX_WIDTH];
    t_mag                     line_lower [MAX_WIDTH];
    logic [2*GRAD_BITS-1:0]   grad_line [MAX_WIDTH];
    t_mag                     win [3][3];
    logic [2*GRAD_BITS-1:0]   grad_hold;
    int                       col_pos;
    int                       row_pos;
    t_width                   cfg_width;
    t_height                  cfg_height;

    t_result pending_results[$];
    int      mismatch_count = 0;
    int      results_checked = 0;
    int      pixels_sent = 0;
    int      reg_writes = 0;
    bit      gaps_enabled = 1'b1;
    int      stall_left = 0;

    function automatic void clear_shadow();
        for (int i = 0; i < MAX_WIDTH; i++) begin
            line_upper[i] = '0;
            line_lower[i] = '0;
            grad_line[i]  = '0;
        end
        for (int k = 0; k < 9; k++)
            win[k / 3][k % 3] = '0;
        grad_hold  = '0;
        col_pos    = 0;
        row_pos    = 0;
        cfg_width  = WIDTH_RESET;
        cfg_height = HEIGHT_RESET;
    endfunction

    // Exact form of m >= w*va + (1-w)*vb with w = minor/major
    function automatic bit beats_interp(longint m, longint major, longint minor,
                                        longint va, longint vb);
        return major * m >= minor * va + (major - minor) * vb;
    endfunction

    // Keep or drop the centre magnitude along its gradient direction
    function automatic t_mag nms_decide(logic [2*GRAD_BITS-1:0] gpair);
        int     gx, gy, ax, ay;
        longint m, major, minor, v1, v2, v3, v4;
        bit     same;
        gx = $signed(gpair[GRAD_BITS-1:0]);
        gy = $signed(gpair[2*GRAD_BITS-1:GRAD_BITS]);
        ax = (gx < 0) ? -gx : gx;
        ay = (gy < 0) ? -gy : gy;
        same = (gx > 0 && gy > 0) || (gx < 0 && gy < 0);
        m = win[1][1];
        if (m == 0)
            return '0;
        if (ay > ax) begin
            major = ay;
            minor = ax;
            v2 = win[0][1];
            v4 = win[2][1];
            if (same) begin
                v1 = win[0][0];
                v3 = win[2][2];
            end else begin
                v1 = win[0][2];
                v3 = win[2][0];
            end
        end else begin
            major = ax;
            minor = ay;
            // flat gradient: unit weight onto the diagonal pair
            if (major == 0) begin
                major = 1;
                minor = 1;
            end
            v2 = win[1][2];
            v4 = win[1][0];
            if (same) begin
                v1 = win[2][2];
                v3 = win[0][0];
            end else begin
                v1 = win[0][2];
                v3 = win[2][0];
            end
        end
        if (beats_interp(m, major, minor, v1, v2) && beats_interp(m, major, minor, v3, v4))
            return t_mag'(m);
        return '0;
    endfunction

    // Advance the shadow by one pixel and queue the result it produces
    function automatic void predict_pixel(t_mag mag, t_grad gx, t_grad gy, logic fs);
        int                     w, h, r, c, rc, cc;
        t_mag                   top, mid;
        logic [2*GRAD_BITS-1:0] centre_g;
        t_result                res;
        w = (cfg_width < 3) ? 3 : (cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width);
        h = (cfg_height < 3) ? 3 : (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg_height);
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h)
            row_pos = 0;
        r = row_pos;
        c = (col_pos >= MAX_WIDTH) ? 0 : col_pos;

        top = line_upper[c];
        mid = line_lower[c];
        line_upper[c] = mid;
        line_lower[c] = mag;
        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = mag;

        centre_g     = grad_hold;
        grad_hold    = grad_line[c];
        grad_line[c] = {gy, gx};

        res.magnitude = '0;
        res.res_valid = (r >= 2 || (r == 1 && c >= 1));
        if (res.res_valid) begin
            if (c >= 1) begin
                rc = r - 1;
                cc = c - 1;
            end else begin
                rc = r - 2;
                cc = w - 1;
            end
            if (!(rc == 0 || rc >= h - 1 || cc == 0 || cc >= w - 1))
                res.magnitude = nms_decide(centre_g);
        end

        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h)
                row_pos = 0;
        end
        pending_results.push_back(res);
    endfunction

    // Receiver: random stall bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if (gaps_enabled && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 9);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Result checker against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: mismatch: result with nothing expected (magnitude %0d valid %0b)",
                         $realtime, o_suppressed_magnitude, o_result_valid);
                mismatch_count++;
            end else begin
                t_result want;
                want = pending_results.pop_front();
                results_checked++;
                if (o_suppressed_magnitude !== want.magnitude) begin
                    $display("%0t: mismatch on suppressed_magnitude: expected %0d, actual %0d",
                             $realtime, want.magnitude, o_suppressed_magnitude);
                    mismatch_count++;
                end
                if (o_result_valid !== want.res_valid) begin
                    $display("%0t: mismatch on result_valid: expected %0b, actual %0b",
                             $realtime, want.res_valid, o_result_valid);
                    mismatch_count++;
                end
            end
        end
    end

    // One pixel request, with an optional gap ahead of it
    task automatic send_pixel(t_mag mag, t_grad gx, t_grad gy, logic fs);
        if (gaps_enabled && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_magnitude   <= mag;
        i_grad_x      <= gx;
        i_grad_y      <= gy;
        i_frame_start <= fs;
        do @(posedge i_clk); while (o_stall);
        predict_pixel(mag, gx, gy, fs);
        pixels_sent++;
    endtask

    function automatic t_mag rand_mag();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return t_mag'($urandom_range(0, 2047));
        endcase
    endfunction

    function automatic t_grad rand_grad();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return GRAD_MOST_NEG;
            2: return t_grad'(1023);
            default: return t_grad'($urandom_range(0, 2047));
        endcase
    endfunction

    task automatic send_random_pixel(logic fs);
        t_grad gx, gy;
        gx = rand_grad();
        // equal axes now and then, so the tie rule gets hit
        if ($urandom_range(0, 7) == 0 && gx != GRAD_MOST_NEG)
            gy = $urandom_range(0, 1) ? gx : -gx;
        else
            gy = rand_grad();
        send_pixel(rand_mag(), gx, gy, fs);
    endtask

    // npix pixels; the first may open a frame, restart_odds adds stray restarts
    task automatic send_frame(int npix, bit first_fs, int restart_odds);
        logic fs;
        for (int i = 0; i < npix; i++) begin
            fs = (i == 0 && first_fs) ||
                 (restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
            send_random_pixel(fs);
        end
    endtask

    // Idle the input side until every expected result is out
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Write width then height back to back
    task automatic write_size(int w, int h);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_IMAGE_WIDTH;
        i_cfg_data  <= CFG_DATA_BITS'(w);
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_width = W_BITS'(w);
        i_cfg_index <= REG_IMAGE_HEIGHT;
        i_cfg_data  <= CFG_DATA_BITS'(h);
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_height = H_BITS'(h);
        i_cfg_valid <= 1'b0;
        reg_writes += 2;
    endtask

    // A few pixels at the reset sizes; all still before the first centre
    task automatic test_reset_sizes();
        send_frame(3, 1'b1, 0);
        drain_results();
    endtask

    // 3-wide column of hand-picked centres, one per row
    task automatic test_directed_cases();
        t_mag  case_mag[9] = '{0, 0, 2047, 1500, 1500, 1200, 1000, 900, 0};
        int    case_gx[9]  = '{0, 100, 0, 300, -1024, 200, -50, 40, 0};
        int    case_gy[9]  = '{0, 5, 0, 100, 1023, -200, -700, -1024, 0};
        t_grad gx, gy;
        write_size(3, 9);
        for (int r = 0; r < 9; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (c == 1 && r >= 1 && r <= 7) begin
                    gx = t_grad'(case_gx[r]);
                    gy = t_grad'(case_gy[r]);
                    send_pixel(case_mag[r], gx, gy, 1'b0);
                end else begin
                    gx = rand_grad();
                    gy = rand_grad();
                    send_pixel(t_mag'($urandom_range(0, 1023)), gx, gy, r == 0 && c == 0);
                end
            end
        end
        drain_results();
    endtask

    // Sizes below the minimum clamp to 3x3; run past the frame end to wrap rows
    task automatic test_size_clamp_low();
        write_size(0, 1);
        send_frame(21, 1'b1, 0);
        drain_results();
    endtask

    // All-ones register data: both sizes clamp to their maximum; a short run into row 0
    task automatic test_widest_rows();
        write_size(13'h1FFF, 13'h1FFF);
        send_frame(40, 1'b1, 0);
        drain_results();
    endtask

    // Narrowest rows at the tallest frame, first rows only
    task automatic test_tallest_frame();
        write_size(2, MAX_HEIGHT);
        send_frame(60, 1'b1, 0);
        drain_results();
    endtask

    // Shrink width while the column counter sits past it, then shrink height
    task automatic test_resize_midframe();
        write_size(8, 6);
        send_frame(29, 1'b1, 0);
        drain_results();
        write_size(5, 6);
        send_frame(17, 1'b0, 0);
        drain_results();
        write_size(5, 3);
        send_frame(25, 1'b0, 0);
        drain_results();
    endtask

    // Frame restarts: stray ones and back-to-back starts on column 0
    task automatic test_frame_restarts();
        write_size(6, 5);
        repeat (3) send_frame(30, 1'b1, 8);
        send_random_pixel(1'b1);
        send_random_pixel(1'b1);
        send_frame(30, 1'b1, 0);
        drain_results();
    endtask

    // Mostly whole small frames, plus overruns, cut-short frames and restarts
    task automatic test_random_frames(int target);
        int start, w, h, ew, eh;
        start = pixels_sent;
        while (pixels_sent - start < target) begin
            drain_results();
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 14);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            write_size(w, h);
            ew = (w < 3) ? 3 : w;
            eh = (h < 3) ? 3 : h;
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 7))
                    0: send_frame(ew * eh + $urandom_range(1, 2 * ew), 1'b1, 0);
                    1: send_frame(ew * eh, 1'b1, 12);
                    2: send_frame($urandom_range(1, ew * eh), 1'b1, 0);
                    default: send_frame(ew * eh, 1'b1, 0);
                endcase
            end
        end
        drain_results();
    endtask

    initial begin
        clear_shadow();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_sizes();
        test_directed_cases();
        test_size_clamp_low();
        test_widest_rows();
        test_tallest_frame();
        test_resize_midframe();
        test_frame_restarts();
        test_random_frames(650);
        gaps_enabled = 1'b0;
        test_random_frames(150);

        // bounded wait for stragglers
        i_valid <= 1'b0;
        for (int n = 0; n < 20000 && pending_results.size() != 0; n++)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t: mismatch: %0d expected results never arrived",
                     $realtime, pending_results.size());
            mismatch_count += pending_results.size();
        end

        $display("Covered %0d pixels, %0d results checked, %0d register writes, %0d mismatches.",
                 pixels_sent, results_checked, reg_writes, mismatch_count);
        $display("Sizes from clamped 3x3 up to all-ones registers, restarts, wraps, resizing.");
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #40_000_000;
        $display("Timeout with %0d results still expected", pending_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/enms_pkg.sv
rtl/enms_ram.sv
rtl/enms_window.sv
rtl/enms_decide.sv
rtl/enms_fifo.sv
rtl/edge_nonmax_suppress_interpolated.sv
tb/edge_nonmax_suppress_interpolated_test.sv
